// ----- src/uvsr_pkg.sv -----
// uvsr_pkg: shared types, widths, register indexes and helpers for the
// unit-vector step retraction block. No dependencies.
`default_nettype none

package uvsr_pkg;

    // fixed field widths
    localparam int FIELD_W   = 24;   // m, d and trial components
    localparam int STEP_W    = 32;   // requested step, signed
    localparam int BOUND_W   = 31;   // default, min and max step
    localparam int SVAL_W    = 32;   // stepped component, saturated
    localparam int SUM_W     = 64;   // sum of squares
    localparam int ROOT_W    = 32;   // integer square root
    localparam int CFG_W     = 32;   // config write data
    localparam int CFG_IDX_W = 2;    // config register index

    localparam int FRAC_BITS_DEF = 20;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEF_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP = 2'd3;

    // reset values of the step registers
    localparam logic [STEP_W-1:0]  REQ_STEP_RST = 32'd1048576;
    localparam logic [BOUND_W-1:0] DEF_STEP_RST = 31'd1048576;
    localparam logic [BOUND_W-1:0] MIN_STEP_RST = 31'd1;
    localparam logic [BOUND_W-1:0] MAX_STEP_RST = 31'h7FFF_FFFF;

    // node data that travels beside the arithmetic
    typedef struct packed {
        logic                      is_mag;
        logic signed [FIELD_W-1:0] m_x;
        logic signed [FIELD_W-1:0] m_y;
        logic signed [FIELD_W-1:0] m_z;
    } t_side;

    // stepped vector
    typedef struct packed {
        logic signed [SVAL_W-1:0] s_x;
        logic signed [SVAL_W-1:0] s_y;
        logic signed [SVAL_W-1:0] s_z;
    } t_svec;

    // step sanitizing: default when not positive, then raise to min, lower to max
    function automatic logic [BOUND_W-1:0] sanitize_step(
        input logic signed [STEP_W-1:0] req,
        input logic [BOUND_W-1:0]       dflt,
        input logic [BOUND_W-1:0]       lo,
        input logic [BOUND_W-1:0]       hi
    );
        logic [BOUND_W-1:0] h;
        h = req[BOUND_W-1:0];
        if (req <= 0) begin
            h = dflt;
        end else begin
            if (h < lo) h = lo;
            if (h > hi) h = hi;
        end
        return h;
    endfunction

endpackage

`default_nettype wire

// ----- src/uvsr_step.sv -----
// uvsr_step: front stages: step multiply, rounding, saturation, squares and
// their sum. Depends on uvsr_pkg.
`default_nettype none

module uvsr_step #(
    parameter int FRAC_BITS = uvsr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  wire logic                              i_valid,
    input  wire uvsr_pkg::t_side                   i_side,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0] i_dir_x,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0] i_dir_y,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0] i_dir_z,
    input  wire logic [uvsr_pkg::BOUND_W-1:0]      i_step,
    output logic                                   o_valid,
    output uvsr_pkg::t_side                        o_side,
    output uvsr_pkg::t_svec                        o_s,
    output logic [uvsr_pkg::SUM_W-1:0]             o_sum
);
    import uvsr_pkg::*;

    localparam int PW = BOUND_W + 1 + FIELD_W;   // product width, signed
    localparam int XW = PW + 1;                  // sum of m and rounded product

    localparam logic signed [XW-1:0] SAT_HI = XW'(64'sh7FFF_FFFF);
    localparam logic signed [XW-1:0] SAT_LO = -XW'(64'sh8000_0000);
    localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

    logic [4:0] r_valid;
    t_side      r_side [5];

    logic signed [FIELD_W-1:0] r1_d [3];
    logic [BOUND_W-1:0]        r1_h;
    logic signed [PW-1:0]      r2_p [3];
    logic signed [SVAL_W-1:0]  r3_s [3];
    logic [SUM_W-1:0]          r4_sq [3];
    logic signed [SVAL_W-1:0]  r4_s [3];
    logic [SUM_W-1:0]          r5_sum;
    logic signed [SVAL_W-1:0]  r5_s [3];

    logic signed [PW-1:0]      n_p [3];
    logic signed [SVAL_W-1:0]  n_s [3];
    logic [SUM_W-1:0]          n_sq [3];
    logic signed [FIELD_W-1:0] m_lane [3];
    logic signed [FIELD_W-1:0] r2_m [3];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[3:0], i_valid};
        end
    end

    // stage 1: capture the node and the step
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r1_d[0]   <= i_dir_x;
            r1_d[1]   <= i_dir_y;
            r1_d[2]   <= i_dir_z;
            r1_h      <= i_step;
        end
    end

    // stage 2: product of step and direction
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_p[k] = PW'(signed'({1'b0, r1_h})) * PW'(r1_d[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[1] <= r_side[0];
            r2_p      <= n_p;
        end
    end

    // stage 3: round to nearest, ties away from zero, add m and saturate
    always_comb begin
        logic [PW-1:0]        mag;
        logic [PW-1:0]        rnd;
        logic signed [XW-1:0] q;
        logic signed [XW-1:0] sw;
        r2_m[0] = r_side[1].m_x;
        r2_m[1] = r_side[1].m_y;
        r2_m[2] = r_side[1].m_z;
        for (int k = 0; k < 3; k++) begin
            mag = r2_p[k][PW-1] ? PW'(-r2_p[k]) : PW'(r2_p[k]);
            rnd = (mag + HALF) >> FRAC_BITS;
            q   = r2_p[k][PW-1] ? -signed'({1'b0, rnd}) : signed'({1'b0, rnd});
            sw  = q + XW'(r2_m[k]);
            if (sw > SAT_HI)      n_s[k] = SVAL_W'(SAT_HI);
            else if (sw < SAT_LO) n_s[k] = SVAL_W'(SAT_LO);
            else                  n_s[k] = SVAL_W'(sw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[2] <= r_side[1];
            r3_s      <= n_s;
        end
    end

    // stage 4: squares of the magnitudes
    always_comb begin
        logic [SVAL_W-1:0] a;
        for (int k = 0; k < 3; k++) begin
            a       = r3_s[k][SVAL_W-1] ? SVAL_W'(-r3_s[k]) : SVAL_W'(r3_s[k]);
            n_sq[k] = SUM_W'(a) * SUM_W'(a);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[3] <= r_side[2];
            r4_sq     <= n_sq;
            r4_s      <= r3_s;
        end
    end

    // stage 5: sum of squares, cannot overflow 64 bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[4] <= r_side[3];
            r5_sum    <= r4_sq[0] + r4_sq[1] + r4_sq[2];
            r5_s      <= r4_s;
        end
    end

    assign m_lane[0] = r_side[4].m_x;
    assign m_lane[1] = r_side[4].m_y;
    assign m_lane[2] = r_side[4].m_z;

    assign o_valid = r_valid[4];
    assign o_side  = r_side[4];
    assign o_s     = '{s_x: r5_s[0], s_y: r5_s[1], s_z: r5_s[2]};
    assign o_sum   = r5_sum;

`ifndef SYNTHESIS
    // a zero sum only comes from an all-zero stepped vector
    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sum == '0) |-> (r5_s[0] == '0 && r5_s[1] == '0 && r5_s[2] == '0))
        else $error("zero sum with non-zero component");
    // pass-through data matches lane view
    a_side_m: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (m_lane[0] == o_side.m_x))
        else $error("side data mismatch");
    // a held stage keeps its valid
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && o_valid) |=> o_valid)
        else $error("valid lost while held");
`endif

endmodule

`default_nettype wire

// ----- src/uvsr_isqrt.sv -----
// uvsr_isqrt: pipelined integer square root of a 64-bit sum, one result bit
// per stage. Depends on uvsr_pkg.
`default_nettype none

module uvsr_isqrt (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire uvsr_pkg::t_side             i_side,
    input  wire uvsr_pkg::t_svec             i_s,
    input  wire logic [uvsr_pkg::SUM_W-1:0]  i_sum,
    output logic                             o_valid,
    output uvsr_pkg::t_side                  o_side,
    output uvsr_pkg::t_svec                  o_s,
    output logic [uvsr_pkg::ROOT_W-1:0]      o_root
);
    import uvsr_pkg::*;

    localparam int NS = ROOT_W;        // one stage per root bit
    localparam int RW = ROOT_W + 3;    // partial remainder

    logic [NS-1:0]     r_valid;
    t_side             r_side [NS];
    t_svec             r_s    [NS];
    logic [SUM_W-1:0]  r_rad  [NS];
    logic [RW-1:0]     r_rem  [NS];
    logic [ROOT_W-1:0] r_root [NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NS-2:0], i_valid};
        end
    end

    // each stage brings down two radicand bits and decides one root bit
    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [SUM_W-1:0]  rad_in;
        logic [RW-1:0]     rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RW-1:0]     cand;
        logic [RW-1:0]     trial;

        if (j == 0) begin : g_first
            assign rad_in  = i_sum;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign rad_in  = r_rad[j-1];
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign cand  = {rem_in[RW-3:0], rad_in[SUM_W-1:SUM_W-2]};
        assign trial = {1'b0, root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[j] <= rad_in << 2;
                if (cand >= trial) begin
                    r_rem[j]  <= cand - trial;
                    r_root[j] <= {root_in[ROOT_W-2:0], 1'b1};
                end else begin
                    r_rem[j]  <= cand;
                    r_root[j] <= {root_in[ROOT_W-2:0], 1'b0};
                end
                if (j == 0) begin
                    r_side[j] <= i_side;
                    r_s[j]    <= i_s;
                end else begin
                    r_side[j] <= r_side[j-1];
                    r_s[j]    <= r_s[j-1];
                end
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_s     = r_s[NS-1];
    assign o_root  = r_root[NS-1];

`ifndef SYNTHESIS
    // the final remainder never exceeds twice the root
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_rem[NS-1] <= {2'b00, o_root, 1'b0}))
        else $error("square root remainder out of range");
    // a zero root only for a zero vector
    a_zero_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_root == '0) |-> (o_s.s_x == '0 && o_s.s_y == '0 && o_s.s_z == '0))
        else $error("zero root with non-zero vector");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && o_valid) |=> o_valid)
        else $error("valid lost while held");
`endif

endmodule

`default_nettype wire

// ----- src/uvsr_div.sv -----
// uvsr_div: pipelined restoring divider, three lanes of
// round(|s| * 2^F / n), one quotient bit per stage. Depends on uvsr_pkg.
`default_nettype none

module uvsr_div #(
    parameter int FRAC_BITS = uvsr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_en,
    input  wire logic                        i_valid,
    input  wire uvsr_pkg::t_side             i_side,
    input  wire uvsr_pkg::t_svec             i_s,
    input  wire logic [uvsr_pkg::ROOT_W-1:0] i_root,
    output logic                             o_valid,
    output uvsr_pkg::t_side                  o_side,
    output logic [2:0]                       o_neg,
    output logic                             o_zero,
    output logic [FRAC_BITS+1:0]             o_q [3]
);
    import uvsr_pkg::*;

    localparam int QB  = FRAC_BITS + 2;          // quotient bits, quotient <= 2^F
    localparam int DVW = SVAL_W + FRAC_BITS + 1; // dividend width
    localparam int RW  = ROOT_W + 1;             // partial remainder
    localparam int NS  = QB + 1;                 // set-up stage plus one per bit

    logic [NS-1:0]     r_valid;
    t_side             r_side [NS];
    logic [2:0]        r_neg  [NS];
    logic [ROOT_W-1:0] r_n    [NS];
    logic [RW-1:0]     r_rem  [NS][3];
    logic [QB-1:0]     r_low  [NS][3];
    logic [QB-1:0]     r_q    [NS][3];

    logic signed [SVAL_W-1:0] s_lane [3];

    assign s_lane[0] = i_s.s_x;
    assign s_lane[1] = i_s.s_y;
    assign s_lane[2] = i_s.s_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[NS-2:0], i_valid};
        end
    end

    // set-up: magnitude, dividend with half divisor for rounding
    always_ff @(posedge i_clk) begin
        logic [SVAL_W-1:0] mag;
        logic [DVW-1:0]    dv;
        if (i_en) begin
            r_side[0] <= i_side;
            r_n[0]    <= i_root;
            for (int k = 0; k < 3; k++) begin
                mag = s_lane[k][SVAL_W-1] ? SVAL_W'(-s_lane[k]) : SVAL_W'(s_lane[k]);
                dv  = (DVW'(mag) << FRAC_BITS) + DVW'(i_root >> 1);
                r_neg[0][k] <= s_lane[k][SVAL_W-1];
                r_rem[0][k] <= RW'(dv >> QB);
                r_low[0][k] <= dv[QB-1:0];
                r_q[0][k]   <= '0;
            end
        end
    end

    // one quotient bit per stage
    for (genvar j = 1; j < NS; j++) begin : g_stage
        always_ff @(posedge i_clk) begin
            logic [RW-1:0] cand;
            if (i_en) begin
                r_side[j] <= r_side[j-1];
                r_neg[j]  <= r_neg[j-1];
                r_n[j]    <= r_n[j-1];
                for (int k = 0; k < 3; k++) begin
                    cand = {r_rem[j-1][k][RW-2:0], r_low[j-1][k][QB-1]};
                    r_low[j][k] <= r_low[j-1][k] << 1;
                    if (cand >= RW'(r_n[j-1])) begin
                        r_rem[j][k] <= cand - RW'(r_n[j-1]);
                        r_q[j][k]   <= {r_q[j-1][k][QB-2:0], 1'b1};
                    end else begin
                        r_rem[j][k] <= cand;
                        r_q[j][k]   <= {r_q[j-1][k][QB-2:0], 1'b0};
                    end
                end
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_neg   = r_neg[NS-1];
    assign o_zero  = (r_n[NS-1] == '0);
    assign o_q     = r_q[NS-1];

`ifndef SYNTHESIS
    // a component never exceeds the norm, so the quotient stays within one
    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_zero && o_side.is_mag) |-> (o_q[0] <= (QB'(1) << FRAC_BITS)))
        else $error("quotient above one");
    // the remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_zero) |-> (r_rem[NS-1][1] < RW'(r_n[NS-1])))
        else $error("divider remainder out of range");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_en && o_valid) |=> o_valid)
        else $error("valid lost while held");
`endif

endmodule

`default_nettype wire

// ----- src/unit_vector_step_retraction.sv -----
// unit_vector_step_retraction: top level; step registers, pipeline control
// and output register. Depends on uvsr_pkg, uvsr_step, uvsr_isqrt, uvsr_div.
`default_nettype none

// Retracts one mesh node per word onto the unit sphere: a magnetic node
// gives (m + h*d) / |m + h*d| in Q4.20, a non-magnetic node passes m through,
// and a zero stepped vector gives zeros with invalid set. One word is taken
// every cycle while not stalled; the word passes the step and sum-of-squares
// stages, the bit-per-stage square root, the bit-per-stage divider and the
// output register. The whole pipeline holds while a finished word waits under
// stall. The user must write the step registers only while the block is
// empty; the block itself does not enforce it.
module unit_vector_step_retraction #(
    parameter int FRAC_BITS = uvsr_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration
    input  wire logic                                  i_cfg_we,
    input  wire logic [uvsr_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [uvsr_pkg::CFG_W-1:0]            i_cfg_data,
    // input words
    input  wire logic                                  i_valid,
    output logic                                       o_stall,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0]   i_mag_x,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0]   i_mag_y,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0]   i_mag_z,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0]   i_dir_x,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0]   i_dir_y,
    input  wire logic signed [uvsr_pkg::FIELD_W-1:0]   i_dir_z,
    input  wire logic                                  i_is_magnetic,
    // result words
    output logic                                       o_valid,
    input  wire logic                                  i_stall,
    output logic signed [uvsr_pkg::FIELD_W-1:0]        o_trial_x,
    output logic signed [uvsr_pkg::FIELD_W-1:0]        o_trial_y,
    output logic signed [uvsr_pkg::FIELD_W-1:0]        o_trial_z,
    output logic                                       o_invalid
);
    import uvsr_pkg::*;

    localparam int QB = FRAC_BITS + 2;
    localparam int QW = (QB > FIELD_W + 1) ? QB : FIELD_W + 1;
    localparam logic [QW-1:0] POS_MAX = QW'(24'h7F_FFFF);
    localparam logic [QW-1:0] NEG_MAX = QW'(25'h080_0000);

    logic [STEP_W-1:0]  r_req_step;
    logic [BOUND_W-1:0] r_def_step;
    logic [BOUND_W-1:0] r_min_step;
    logic [BOUND_W-1:0] r_max_step;

    logic en;
    logic [BOUND_W-1:0] step_h;
    t_side in_side;

    logic               st_valid;
    t_side              st_side;
    t_svec              st_s;
    logic [SUM_W-1:0]   st_sum;

    logic               sq_valid;
    t_side              sq_side;
    t_svec              sq_s;
    logic [ROOT_W-1:0]  sq_root;

    logic               dv_valid;
    t_side              dv_side;
    logic [2:0]         dv_neg;
    logic               dv_zero;
    logic [QB-1:0]      dv_q [3];

    logic                      r_out_valid;
    logic signed [FIELD_W-1:0] r_trial [3];
    logic                      r_invalid;
    logic signed [FIELD_W-1:0] n_trial [3];
    logic signed [FIELD_W-1:0] m_out [3];

    // step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_step <= REQ_STEP_RST;
            r_def_step <= DEF_STEP_RST;
            r_min_step <= MIN_STEP_RST;
            r_max_step <= MAX_STEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REQ_STEP: r_req_step <= i_cfg_data;
                CFG_DEF_STEP: r_def_step <= i_cfg_data[BOUND_W-1:0];
                CFG_MIN_STEP: r_min_step <= i_cfg_data[BOUND_W-1:0];
                CFG_MAX_STEP: r_max_step <= i_cfg_data[BOUND_W-1:0];
                default: ;
            endcase
        end
    end

    assign step_h = sanitize_step(signed'(r_req_step), r_def_step, r_min_step, r_max_step);

    // the pipeline advances unless a finished word is held
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    assign in_side = '{is_mag: i_is_magnetic, m_x: i_mag_x, m_y: i_mag_y, m_z: i_mag_z};

    uvsr_step #(.FRAC_BITS(FRAC_BITS)) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_side  (in_side),
        .i_dir_x (i_dir_x),
        .i_dir_y (i_dir_y),
        .i_dir_z (i_dir_z),
        .i_step  (step_h),
        .o_valid (st_valid),
        .o_side  (st_side),
        .o_s     (st_s),
        .o_sum   (st_sum)
    );

    uvsr_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (st_valid),
        .i_side  (st_side),
        .i_s     (st_s),
        .i_sum   (st_sum),
        .o_valid (sq_valid),
        .o_side  (sq_side),
        .o_s     (sq_s),
        .o_root  (sq_root)
    );

    uvsr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (sq_valid),
        .i_side  (sq_side),
        .i_s     (sq_s),
        .i_root  (sq_root),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_neg   (dv_neg),
        .o_zero  (dv_zero),
        .o_q     (dv_q)
    );

    // final saturation and sign, pass-through and zero-norm cases
    assign m_out[0] = dv_side.m_x;
    assign m_out[1] = dv_side.m_y;
    assign m_out[2] = dv_side.m_z;

    always_comb begin
        logic [QW-1:0] q;
        for (int k = 0; k < 3; k++) begin
            q = QW'(dv_q[k]);
            if (!dv_side.is_mag) begin
                n_trial[k] = m_out[k];
            end else if (dv_zero) begin
                n_trial[k] = '0;
            end else if (dv_neg[k]) begin
                if (q > NEG_MAX) q = NEG_MAX;
                n_trial[k] = FIELD_W'(-q);
            end else begin
                if (q > POS_MAX) q = POS_MAX;
                n_trial[k] = FIELD_W'(q);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_trial   <= n_trial;
            r_invalid <= dv_side.is_mag && dv_zero;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_trial_x = r_trial[0];
    assign o_trial_y = r_trial[1];
    assign o_trial_z = r_trial[2];
    assign o_invalid = r_invalid;

`ifndef SYNTHESIS
    // an invalid word carries a zero vector
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_trial_x == '0 && o_trial_y == '0 && o_trial_z == '0))
        else $error("invalid word with non-zero vector");
    // stall on the input side only comes from a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall without a held result");
    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
`endif

endmodule

`default_nettype wire
